>>> sv/pts_pkg.sv
package pts_pkg;

  localparam int MAX_TASKS  = 16;
  localparam int NUM_LEVELS = 4;
  localparam int SLOT_W     = $clog2(MAX_TASKS);
  localparam int SLOTX_W    = $clog2(MAX_TASKS + 1);
  localparam int LVL_W      = $clog2(NUM_LEVELS);
  localparam int ID_W       = 16;
  localparam int QDEPTH     = 2;

  localparam logic [SLOTX_W-1:0] NO_SLOT = SLOTX_W'(MAX_TASKS);

  typedef enum logic [2:0] {
    OP_CREATE = 3'd0,
    OP_YIELD  = 3'd1,
    OP_EXIT   = 3'd2,
    OP_OWN    = 3'd3,
    OP_PARENT = 3'd4
  } op_t;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_SLOT   = 2'd1;
  localparam logic [1:0] ST_NO_RUN    = 2'd2;
  localparam logic [1:0] ST_NO_PARENT = 2'd3;

  typedef struct packed {
    logic [2:0] operation;
    logic [1:0] priority_req;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] value;
    logic        running_valid;
    logic [15:0] running_id;
  } out_item_t;

  // Classified command handed from the front to the back.
  typedef struct packed {
    logic [2:0]       op;
    logic [LVL_W-1:0] lvl;
  } cmd_t;

endpackage

>>> sv/pts_front.sv
module pts_front (
  input  logic              clk,
  input  logic              rst_n,
  input  pts_pkg::in_item_t in_item,
  input  logic              in_push,
  output logic              in_full,
  output pts_pkg::cmd_t     q_data,
  output logic              q_valid,
  input  logic              q_take
);

  localparam int PW = $clog2(pts_pkg::QDEPTH);

  pts_pkg::cmd_t    buf_r [pts_pkg::QDEPTH];
  logic [PW-1:0]    wp_r, rp_r;
  logic [PW:0]      cnt_r;
  pts_pkg::cmd_t    cmd;
  logic             wr, rd;

  // Priorities above the top level saturate.
  always_comb begin
    cmd.op = in_item.operation;
    if (32'(in_item.priority_req) >= pts_pkg::NUM_LEVELS) begin
      cmd.lvl = pts_pkg::LVL_W'(pts_pkg::NUM_LEVELS - 1);
    end else begin
      cmd.lvl = pts_pkg::LVL_W'(in_item.priority_req);
    end
  end

  assign in_full = (cnt_r == (PW+1)'(pts_pkg::QDEPTH));
  assign wr      = in_push && !in_full;
  assign rd      = q_take && q_valid;
  assign q_valid = (cnt_r != '0);
  assign q_data  = buf_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + 1'b1;
      if (rd) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (PW+1)'(wr) - (PW+1)'(rd);
    end
    if (wr) buf_r[wp_r] <= cmd;
  end

endmodule

>>> sv/pts_back.sv
module pts_back (
  input  logic               clk,
  input  logic               rst_n,
  input  pts_pkg::cmd_t      q_data,
  input  logic               q_valid,
  output logic               q_take,
  output pts_pkg::out_item_t out_item,
  output logic               out_empty,
  input  logic               out_pop
);

  localparam int SW = pts_pkg::SLOT_W;
  localparam int XW = pts_pkg::SLOTX_W;
  localparam int LW = pts_pkg::LVL_W;
  localparam int NT = pts_pkg::MAX_TASKS;
  localparam int NL = pts_pkg::NUM_LEVELS;

  typedef enum logic [2:0] {S_IDLE, S_EXEC, S_SCAN, S_DONE} state_t;

  state_t         state_r;
  pts_pkg::cmd_t  cmd_r;
  logic [XW-1:0]  free_link_r [NT];
  logic [XW-1:0]  free_head_r, free_tail_r;
  logic [XW-1:0]  ready_link_r [NT];
  logic [XW-1:0]  level_head_r [NL];
  logic [SW-1:0]  level_tail_r [NL];
  logic [15:0]    slot_id_r [NT];
  logic [LW-1:0]  slot_level_r [NT];
  logic [XW-1:0]  slot_parent_r [NT];
  logic [XW-1:0]  running_r;
  logic [15:0]    id_counter_r;
  logic [LW:0]    scan_r;      // level being scanned, plus one
  logic [1:0]     status_r;
  logic [15:0]    value_r;
  logic           out_full_r;
  pts_pkg::out_item_t out_r;

  logic           running;
  logic [SW-1:0]  rs;
  logic [LW-1:0]  scan_l;
  logic [LW:0]    floor_l;

  assign running   = (running_r != pts_pkg::NO_SLOT);
  assign rs        = running_r[SW-1:0];
  assign scan_l    = LW'(scan_r - 1'b1);
  assign floor_l   = running ? (LW+1)'(slot_level_r[rs]) : '0;
  assign q_take    = (state_r == S_IDLE) && q_valid;
  assign out_empty = !out_full_r;
  assign out_item  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      free_head_r <= '0;
      free_tail_r <= XW'(NT - 1);
      for (int i = 0; i < NT; i++) begin
        free_link_r[i] <= (i == NT - 1) ? pts_pkg::NO_SLOT : XW'(i + 1);
      end
      for (int i = 0; i < NL; i++) level_head_r[i] <= pts_pkg::NO_SLOT;
      running_r    <= pts_pkg::NO_SLOT;
      id_counter_r <= '0;
      out_full_r   <= 1'b0;
    end else begin
      if (out_pop && out_full_r && state_r != S_DONE) out_full_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            cmd_r    <= q_data;
            status_r <= pts_pkg::ST_OK;
            value_r  <= '0;
            state_r  <= S_EXEC;
          end
        end
        S_EXEC: begin
          state_r <= S_DONE;
          unique case (cmd_r.op)
            pts_pkg::OP_CREATE: begin
              if (free_head_r == pts_pkg::NO_SLOT) begin
                status_r <= pts_pkg::ST_NO_SLOT;
              end else begin
                free_head_r <= free_link_r[free_head_r[SW-1:0]];
                id_counter_r <= id_counter_r + 1'b1;
                slot_id_r[free_head_r[SW-1:0]]     <= id_counter_r;
                slot_level_r[free_head_r[SW-1:0]]  <= cmd_r.lvl;
                slot_parent_r[free_head_r[SW-1:0]] <= running_r;
                value_r <= id_counter_r;
                if (id_counter_r == '0) begin
                  if (running) begin
                    ready_link_r[rs] <= pts_pkg::NO_SLOT;
                    if (level_head_r[slot_level_r[rs]] == pts_pkg::NO_SLOT)
                      level_head_r[slot_level_r[rs]] <= running_r;
                    else
                      ready_link_r[level_tail_r[slot_level_r[rs]]] <= running_r;
                    level_tail_r[slot_level_r[rs]] <= rs;
                  end
                  running_r <= free_head_r;
                end else begin
                  ready_link_r[free_head_r[SW-1:0]] <= pts_pkg::NO_SLOT;
                  if (level_head_r[cmd_r.lvl] == pts_pkg::NO_SLOT)
                    level_head_r[cmd_r.lvl] <= free_head_r;
                  else
                    ready_link_r[level_tail_r[cmd_r.lvl]] <= free_head_r;
                  level_tail_r[cmd_r.lvl] <= free_head_r[SW-1:0];
                  scan_r  <= (LW+1)'(NL);
                  state_r <= S_SCAN;
                end
              end
            end
            pts_pkg::OP_YIELD: begin
              if (!running) status_r <= pts_pkg::ST_NO_RUN;
              else begin
                scan_r  <= (LW+1)'(NL);
                state_r <= S_SCAN;
              end
            end
            pts_pkg::OP_EXIT: begin
              if (!running) status_r <= pts_pkg::ST_NO_RUN;
              else begin
                free_link_r[rs] <= pts_pkg::NO_SLOT;
                if (free_head_r == pts_pkg::NO_SLOT) free_head_r <= running_r;
                else free_link_r[free_tail_r[SW-1:0]] <= running_r;
                free_tail_r <= running_r;
                running_r   <= pts_pkg::NO_SLOT;
                scan_r      <= (LW+1)'(NL);
                state_r     <= S_SCAN;
              end
            end
            pts_pkg::OP_OWN: begin
              if (!running) status_r <= pts_pkg::ST_NO_RUN;
              else value_r <= slot_id_r[rs];
            end
            pts_pkg::OP_PARENT: begin
              if (!running) status_r <= pts_pkg::ST_NO_RUN;
              else if (slot_parent_r[rs] == pts_pkg::NO_SLOT)
                status_r <= pts_pkg::ST_NO_PARENT;
              else value_r <= slot_id_r[slot_parent_r[rs][SW-1:0]];
            end
            default: ;
          endcase
        end
        S_SCAN: begin
          // One level per cycle, from the top down to the floor.
          if (scan_r <= floor_l) begin
            state_r <= S_DONE;
          end else if (level_head_r[scan_l] != pts_pkg::NO_SLOT) begin
            // When the running task sits at this level and the head is the
            // only entry, the running task becomes the whole queue.
            if (running && slot_level_r[rs] == scan_l &&
                ready_link_r[level_head_r[scan_l][SW-1:0]] == pts_pkg::NO_SLOT)
              level_head_r[scan_l] <= running_r;
            else
              level_head_r[scan_l] <= ready_link_r[level_head_r[scan_l][SW-1:0]];
            if (running) begin
              ready_link_r[rs] <= pts_pkg::NO_SLOT;
              if (level_head_r[slot_level_r[rs]] == pts_pkg::NO_SLOT)
                level_head_r[slot_level_r[rs]] <= running_r;
              else if (slot_level_r[rs] != scan_l ||
                       ready_link_r[level_head_r[scan_l][SW-1:0]] != pts_pkg::NO_SLOT)
                ready_link_r[level_tail_r[slot_level_r[rs]]] <= running_r;
              level_tail_r[slot_level_r[rs]] <= rs;
            end
            running_r <= level_head_r[scan_l];
            state_r   <= S_DONE;
          end else begin
            scan_r <= scan_r - 1'b1;
          end
        end
        S_DONE: begin
          if (!out_full_r || out_pop) begin
            out_r.status        <= status_r;
            out_r.value         <= value_r;
            out_r.running_valid <= running;
            out_r.running_id    <= running ? slot_id_r[rs] : '0;
            out_full_r          <= 1'b1;
            state_r             <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_done_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_full_r && !out_pop) |=> state_r == S_DONE)
    else $error("result overwritten");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_full_r && !out_pop) |=> $stable(out_r))
    else $error("held result changed");
  a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_take |=> state_r == S_EXEC)
    else $error("command lost");

endmodule

>>> sv/priority_task_scheduler.sv
// Priority task scheduler: task slots, a free-slot FIFO and one FIFO ready
// queue per priority level, driven by scheduler calls.
// Input channel: in_item (operation, priority_req) is transferred when in_push
// is high and in_full is low. A two-entry command queue sits between the
// front, which classifies calls, and the back, which executes them.
// Result channel: one result per call. It is shown while out_empty is low and
// transferred when out_pop is high.
// A call passes through three steps in the back (start, execute, deliver).
// A reschedule adds a scan of the priority levels from the top down, which
// stops at the first level with a ready task or, if every level is empty,
// at the floor.
// Reset (synchronous, rst_n low) chains all slots into the free FIFO, empties
// every level and leaves no task running; the result register is empty.
// When the receiver stalls, the result holds, the back waits in its deliver
// step and the command queue absorbs up to two more calls before in_full.
module priority_task_scheduler (
  input  logic               clk,
  input  logic               rst_n,
  input  pts_pkg::in_item_t  in_item,
  input  logic               in_push,
  output logic               in_full,
  output pts_pkg::out_item_t out_item,
  output logic               out_empty,
  input  logic               out_pop
);

  pts_pkg::cmd_t q_data;
  logic          q_valid, q_take;

  pts_front u_front (
    .clk, .rst_n, .in_item, .in_push, .in_full,
    .q_data, .q_valid, .q_take
  );

  pts_back u_back (
    .clk, .rst_n, .q_data, .q_valid, .q_take,
    .out_item, .out_empty, .out_pop
  );

endmodule
